>>> src/wavhp_pkg.sv
// wavhp_pkg: shared types, constants and result packing for the wave header parser
// no dependencies; used by the channel interfaces, the chunk walker and the top level
package wavhp_pkg;

  // buffer bytes that are parsed; later bytes only count for the last flag
  localparam int HEADER_BYTES = 4096;
  localparam int CountW = $clog2(HEADER_BYTES + 1);
  localparam int MIN_BYTES = 44;
  localparam int OffsetW = 13;

  typedef logic [3:0][7:0] tag_t;

  // element 0 is the first byte in the file
  localparam tag_t TAG_RIFF = {8'h46, 8'h46, 8'h49, 8'h52};
  localparam tag_t TAG_WAVE = {8'h45, 8'h56, 8'h41, 8'h57};
  localparam tag_t TAG_FMT  = {8'h20, 8'h74, 8'h6D, 8'h66};
  localparam tag_t TAG_DATA = {8'h61, 8'h74, 8'h61, 8'h64};

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_NO_RIFF = 3'd2,
    ST_NO_WAVE = 3'd3,
    ST_NO_DATA = 3'd4,
    ST_NO_FMT  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] sample_hz;
    logic [31:0] bytes_per_sec;
    logic [15:0] frame_bytes;
    logic [15:0] bits_per_sample;
  } fmt_t;

  typedef struct packed {
    status_t             status;
    logic [15:0]         format_code;
    logic [15:0]         channel_count;
    logic [31:0]         sample_hz;
    logic [31:0]         bytes_per_sec;
    logic [15:0]         frame_bytes;
    logic [15:0]         bits_per_sample;
    logic [OffsetW-1:0]  payload_offset;
    logic [31:0]         payload_size;
  } result_t;

  // parser view after the byte in flight has been taken
  typedef struct packed {
    logic [CountW-1:0]  count;
    logic               riff_bad;
    logic               wave_bad;
    logic               fmt_seen;
    logic               data_found;
    fmt_t               fmt;
    logic [OffsetW-1:0] offset;
    logic [31:0]        size;
  } summary_t;

  function automatic result_t build_result(summary_t s);
    result_t r;
    r = '0;
    priority if (s.count < CountW'(MIN_BYTES)) begin
      r.status = ST_SHORT;
    end else if (s.riff_bad) begin
      r.status = ST_NO_RIFF;
    end else if (s.wave_bad) begin
      r.status = ST_NO_WAVE;
    end else if (!s.data_found) begin
      r.status = ST_NO_DATA;
    end else if (!s.fmt_seen) begin
      r.status = ST_NO_FMT;
    end else begin
      r.status = ST_OK;
    end
    // early errors leave every other field at zero
    if (r.status == ST_OK || r.status == ST_NO_DATA || r.status == ST_NO_FMT) begin
      if (s.fmt_seen) begin
        r.format_code     = s.fmt.format_code;
        r.channel_count   = s.fmt.channel_count;
        r.sample_hz       = s.fmt.sample_hz;
        r.bytes_per_sec   = s.fmt.bytes_per_sec;
        r.frame_bytes     = s.fmt.frame_bytes;
        r.bits_per_sample = s.fmt.bits_per_sample;
      end
      if (s.data_found) begin
        r.payload_offset = s.offset;
        r.payload_size   = s.size;
      end
    end
    return r;
  endfunction

endpackage

>>> src/wavhp_ifs.sv
// wavhp_ifs: valid/ready channel interfaces for header bytes and parse results
// depends on wavhp_pkg for the payload types
interface wavhp_byte_if;
  logic           valid;
  logic           ready;
  wavhp_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wavhp_result_if;
  logic               valid;
  logic               ready;
  wavhp_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/wavhp_walker.sv
// wavhp_walker: per-byte tag checks, chunk walk, fmt capture and data chunk capture
// depends on wavhp_pkg; summary shows the state as it stands after the current byte
module wavhp_walker (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          header_byte,
  input  logic                is_last,
  output wavhp_pkg::summary_t summary
);

  localparam int CountW  = wavhp_pkg::CountW;
  localparam int OffsetW = wavhp_pkg::OffsetW;

  logic [CountW-1:0]  count, count_next;
  logic [7:0]         hdr [7];
  logic [7:0]         hdr_next [7];
  logic [2:0]         hdr_idx, hdr_idx_next;
  logic [32:0]        skip, skip_next;
  logic [7:0]         fmt [16];
  logic [7:0]         fmt_next [16];
  logic [3:0]         fmt_idx, fmt_idx_next;
  logic               riff_bad, riff_bad_next;
  logic               wave_bad, wave_bad_next;
  logic               fmt_seen, fmt_seen_next;
  logic               data_found, data_found_next;
  logic               capture, capture_next;
  logic [OffsetW-1:0] found_offset, found_offset_next;
  logic [31:0]        found_size, found_size_next;

  logic [CountW:0]    pos_inc;
  logic [31:0]        chunk_size;
  logic [32:0]        padded;
  wavhp_pkg::tag_t    chunk_tag;

  assign pos_inc    = (CountW + 1)'(count) + 1'b1;
  assign chunk_size = {header_byte, hdr[6], hdr[5], hdr[4]};
  assign padded     = ({1'b0, chunk_size} + 33'd1) & ~33'd1;
  assign chunk_tag  = {hdr[3], hdr[2], hdr[1], hdr[0]};

  always_comb begin
    count_next        = count;
    hdr_next          = hdr;
    hdr_idx_next      = hdr_idx;
    skip_next         = skip;
    fmt_next          = fmt;
    fmt_idx_next      = fmt_idx;
    riff_bad_next     = riff_bad;
    wave_bad_next     = wave_bad;
    fmt_seen_next     = fmt_seen;
    data_found_next   = data_found;
    capture_next      = capture;
    found_offset_next = found_offset;
    found_size_next   = found_size;

    if (count < CountW'(wavhp_pkg::HEADER_BYTES)) begin
      count_next = pos_inc[CountW-1:0];
      if (count < CountW'(4)) begin
        if (header_byte != wavhp_pkg::TAG_RIFF[count[1:0]]) riff_bad_next = 1'b1;
      end else if (count < CountW'(8)) begin
        // file size field, not checked
      end else if (count < CountW'(12)) begin
        if (header_byte != wavhp_pkg::TAG_WAVE[count[1:0]]) wave_bad_next = 1'b1;
      end else begin
        // fmt capture runs on whatever bytes follow the fmt header
        if (capture) begin
          fmt_next[fmt_idx] = header_byte;
          fmt_idx_next      = fmt_idx + 4'd1;
          if (fmt_idx == 4'd15) capture_next = 1'b0;
        end
        if (!data_found) begin
          if (skip != 33'd0) begin
            skip_next = skip - 33'd1;
          end else if (hdr_idx != 3'd7) begin
            hdr_next[hdr_idx] = header_byte;
            hdr_idx_next      = hdr_idx + 3'd1;
          end else begin
            hdr_idx_next = 3'd0;
            if (chunk_tag == wavhp_pkg::TAG_FMT) begin
              fmt_seen_next = 1'b1;
              capture_next  = 1'b1;
              for (int i = 0; i < 16; i++) fmt_next[i] = 8'd0;
              fmt_idx_next  = 4'd0;
              skip_next     = padded;
            end else if (chunk_tag == wavhp_pkg::TAG_DATA) begin
              data_found_next   = 1'b1;
              found_offset_next = OffsetW'(pos_inc);
              found_size_next   = padded[31:0];
            end else begin
              skip_next = padded;
            end
          end
        end
      end
    end
  end

  always_comb begin
    summary.count                = count_next;
    summary.riff_bad             = riff_bad_next;
    summary.wave_bad             = wave_bad_next;
    summary.fmt_seen             = fmt_seen_next;
    summary.data_found           = data_found_next;
    summary.fmt.format_code      = {fmt_next[1], fmt_next[0]};
    summary.fmt.channel_count    = {fmt_next[3], fmt_next[2]};
    summary.fmt.sample_hz        = {fmt_next[7], fmt_next[6], fmt_next[5], fmt_next[4]};
    summary.fmt.bytes_per_sec    = {fmt_next[11], fmt_next[10], fmt_next[9], fmt_next[8]};
    summary.fmt.frame_bytes      = {fmt_next[13], fmt_next[12]};
    summary.fmt.bits_per_sample  = {fmt_next[15], fmt_next[14]};
    summary.offset               = found_offset_next;
    summary.size                 = found_size_next;
  end

  // control state; the last byte of a buffer returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (take && is_last)) begin
      count        <= '0;
      hdr_idx      <= '0;
      skip         <= '0;
      fmt_idx      <= '0;
      riff_bad     <= 1'b0;
      wave_bad     <= 1'b0;
      fmt_seen     <= 1'b0;
      data_found   <= 1'b0;
      capture      <= 1'b0;
      found_offset <= '0;
      found_size   <= '0;
    end else if (take) begin
      count        <= count_next;
      hdr_idx      <= hdr_idx_next;
      skip         <= skip_next;
      fmt_idx      <= fmt_idx_next;
      riff_bad     <= riff_bad_next;
      wave_bad     <= wave_bad_next;
      fmt_seen     <= fmt_seen_next;
      data_found   <= data_found_next;
      capture      <= capture_next;
      found_offset <= found_offset_next;
      found_size   <= found_size_next;
    end
  end

  // byte stores, read only after being written or cleared in this buffer
  always_ff @(posedge clk) begin
    if (take) begin
      hdr <= hdr_next;
      fmt <= fmt_next;
    end
  end

endmodule

>>> src/wav_header_chunk_parser_core.sv
// result: registered when the byte flagged last leaves the input register;
// throughput: one header byte per cycle, set by the walker update, unless stalled;
// the input register stalls only while a result waits and the next byte is also last
// reset: synchronous, clears parser control and handshake valid state, no sweep;
// after each result the parser returns to its reset state for the next buffer
// depends on wavhp_pkg, wavhp_ifs and wavhp_walker
module wav_header_chunk_parser_core (
  input  logic                  clk,
  input  logic                  rst,
  wavhp_byte_if.sink            byte_ch,
  wavhp_result_if.source        result_ch
);

  // input register holding one transferred byte
  logic                s1_valid;
  wavhp_pkg::in_t      s1_data;
  logic                s1_adv;

  // result register
  logic                out_valid;
  wavhp_pkg::result_t  out_data;

  wavhp_pkg::summary_t summary;

  // a non-last byte never needs the result register, so it always moves on;
  // a last byte moves when the result register is empty or being emptied
  assign s1_adv = s1_valid && (!s1_data.is_last || !out_valid || result_ch.ready);

  assign byte_ch.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      s1_valid <= byte_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      s1_data <= byte_ch.data;
    end
  end

  // chunk walker updates on each byte leaving the input register
  wavhp_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .take        (s1_adv),
    .header_byte (s1_data.header_byte),
    .is_last     (s1_data.is_last),
    .summary     (summary)
  );

  // result capture, held until the result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_data.is_last) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_data.is_last) begin
      out_data <= wavhp_pkg::build_result(summary);
    end
  end

  assign result_ch.valid = out_valid;
  assign result_ch.data  = out_data;

  // a last byte that moves on always leaves a result behind
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_data.is_last |=> out_valid)
    else $error("last byte left no result");

  // the input side stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !byte_ch.ready |-> s1_valid && s1_data.is_last && out_valid && !result_ch.ready)
    else $error("input stalled without a waiting result");

  // padded data size is always even
  a_size_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_data.payload_size[0])
    else $error("odd data size");

  // a good file has its data payload after the wave tag and one chunk header
  a_ok_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == wavhp_pkg::ST_OK |-> out_data.payload_offset >= 13'd20)
    else $error("data offset too small for a good file");

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for the wave header parser, one header buffer per result
// depends on wavhp_pkg, the wavhp_ifs channel interfaces and wav_header_chunk_parser_core
module tb_top;

  // format codes used to bias the random fmt chunks
  localparam logic [15:0] FMT_PCM = 16'h0001;
  localparam logic [15:0] FMT_FLOAT = 16'h0003;
  localparam logic [15:0] FMT_ALAW = 16'h0006;
  localparam logic [15:0] FMT_MULAW = 16'h0007;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

  // "LIST", a common chunk that the parser has to skip
  localparam wavhp_pkg::tag_t TAG_LIST = {8'h54, 8'h53, 8'h49, 8'h4C};

  localparam int RANDOM_BYTES_PER_PHASE = 250;
  localparam int MIN_RANDOM_FILES = 12;
  localparam int DRAIN_CYCLES = 20;

  // ---------------------------------------------------------------------------
  // expected-result tracker: walks the header bytes the same way the block should
  // and keeps the results that the block still owes us
  // ---------------------------------------------------------------------------
  class header_parse_tracker;
    wavhp_pkg::result_t pending_results[$];
    int unsigned mismatches;

    // walker state for the buffer in progress
    int unsigned taken;
    logic [7:0] chunk_hdr[8];
    int unsigned chunk_idx;
    logic [32:0] skip_left;
    logic [7:0] fmt_raw[16];
    int unsigned fmt_idx;
    logic riff_bad, wave_bad, fmt_seen, data_found, capturing;
    logic [wavhp_pkg::OffsetW-1:0] data_pos;
    logic [31:0] data_len;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      taken = 0;
      chunk_idx = 0;
      skip_left = '0;
      fmt_idx = 0;
      riff_bad = 1'b0;
      wave_bad = 1'b0;
      fmt_seen = 1'b0;
      data_found = 1'b0;
      capturing = 1'b0;
      data_pos = '0;
      data_len = '0;
      foreach (chunk_hdr[i]) chunk_hdr[i] = '0;
      foreach (fmt_raw[i]) fmt_raw[i] = '0;
    endfunction

    function void walk(int unsigned p, logic [7:0] b);
      wavhp_pkg::tag_t tag;
      logic [32:0] padded;
      if (p < 4) begin
        if (b != wavhp_pkg::TAG_RIFF[p]) riff_bad = 1'b1;
        return;
      end
      if (p < 8) return;
      if (p < 12) begin
        if (b != wavhp_pkg::TAG_WAVE[p - 8]) wave_bad = 1'b1;
        return;
      end
      // fmt capture runs on every byte, even past the data header
      if (capturing && fmt_idx < 16) begin
        fmt_raw[fmt_idx] = b;
        fmt_idx++;
        if (fmt_idx >= 16) capturing = 1'b0;
      end
      if (data_found) return;
      if (skip_left != 0) begin
        skip_left--;
        return;
      end
      chunk_hdr[chunk_idx] = b;
      if (chunk_idx < 7) begin
        chunk_idx++;
        return;
      end
      chunk_idx = 0;
      for (int k = 0; k < 4; k++) tag[k] = chunk_hdr[k];
      padded = ({1'b0, chunk_hdr[7], chunk_hdr[6], chunk_hdr[5], chunk_hdr[4]} + 33'd1)
               & ~33'd1;
      if (tag == wavhp_pkg::TAG_FMT) begin
        fmt_seen = 1'b1;
        capturing = 1'b1;
        foreach (fmt_raw[i]) fmt_raw[i] = '0;
        fmt_idx = 0;
        skip_left = padded;
      end else if (tag == wavhp_pkg::TAG_DATA) begin
        data_found = 1'b1;
        data_pos = wavhp_pkg::OffsetW'(p + 1);
        data_len = padded[31:0];
      end else begin
        skip_left = padded;
      end
    endfunction

    // called for every accepted byte; queues a result on the last one
    function void take_header_byte(logic [7:0] b, logic last);
      wavhp_pkg::result_t r;
      if (taken < wavhp_pkg::HEADER_BYTES) begin
        walk(taken, b);
        taken++;
      end
      if (!last) return;
      r = '0;
      if (taken < wavhp_pkg::MIN_BYTES) begin
        r.status = wavhp_pkg::ST_SHORT;
      end else if (riff_bad) begin
        r.status = wavhp_pkg::ST_NO_RIFF;
      end else if (wave_bad) begin
        r.status = wavhp_pkg::ST_NO_WAVE;
      end else if (!data_found) begin
        r.status = wavhp_pkg::ST_NO_DATA;
      end else if (!fmt_seen) begin
        r.status = wavhp_pkg::ST_NO_FMT;
      end else begin
        r.status = wavhp_pkg::ST_OK;
      end
      if (r.status == wavhp_pkg::ST_OK || r.status == wavhp_pkg::ST_NO_DATA ||
          r.status == wavhp_pkg::ST_NO_FMT) begin
        if (fmt_seen) begin
          r.format_code = {fmt_raw[1], fmt_raw[0]};
          r.channel_count = {fmt_raw[3], fmt_raw[2]};
          r.sample_hz = {fmt_raw[7], fmt_raw[6], fmt_raw[5], fmt_raw[4]};
          r.bytes_per_sec = {fmt_raw[11], fmt_raw[10], fmt_raw[9], fmt_raw[8]};
          r.frame_bytes = {fmt_raw[13], fmt_raw[12]};
          r.bits_per_sample = {fmt_raw[15], fmt_raw[14]};
        end
        if (data_found) begin
          r.payload_offset = data_pos;
          r.payload_size = data_len;
        end
      end
      pending_results.push_back(r);
      restart();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(wavhp_pkg::result_t got);
      wavhp_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no expectation pending, status %0d", got.status);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("format_code", 32'(want.format_code), 32'(got.format_code));
      compare_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
      compare_field("sample_hz", want.sample_hz, got.sample_hz);
      compare_field("bytes_per_sec", want.bytes_per_sec, got.bytes_per_sec);
      compare_field("frame_bytes", 32'(want.frame_bytes), 32'(got.frame_bytes));
      compare_field("bits_per_sample", 32'(want.bits_per_sample),
                    32'(got.bits_per_sample));
      compare_field("payload_offset", 32'(want.payload_offset), 32'(got.payload_offset));
      compare_field("payload_size", want.payload_size, got.payload_size);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, channels and the block
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst;

  wavhp_byte_if byte_ch();
  wavhp_result_if result_ch();

  wav_header_chunk_parser_core dut (
    .clk(clk),
    .rst(rst),
    .byte_ch(byte_ch),
    .result_ch(result_ch)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  header_parse_tracker tracker;

  // idle percentages, changed per phase by the main sequence
  int send_idle_pct;
  int recv_stall_pct;

  // buffer under construction and running totals
  logic [7:0] file_bytes[$];
  int bytes_sent;
  int random_files;

  // ---------------------------------------------------------------------------
  // result side: check every transfer, then pick ready for the next cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) tracker.check_result(result_ch.data);
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------

  // one byte transfer; optional idle cycles first, then hold until ready
  task automatic push_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data.header_byte <= b;
    byte_ch.data.is_last <= last;
    do @(posedge clk); while (!byte_ch.ready);
    tracker.take_header_byte(b, last);
  endtask

  // send the built buffer, flagging its final byte as last
  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      push_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
    bytes_sent += file_bytes.size();
    file_bytes.delete();
  endtask

  // hold off the sender until every owed result has come back
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // buffer builders
  // ---------------------------------------------------------------------------
  function automatic void put_le(logic [31:0] v, int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void put_tag(wavhp_pkg::tag_t t);
    for (int k = 0; k < 4; k++) file_bytes.push_back(t[k]);
  endfunction

  function automatic void put_rand(int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void put_riff_head();
    put_tag(wavhp_pkg::TAG_RIFF);
    put_le($urandom, 4);
    put_tag(wavhp_pkg::TAG_WAVE);
  endfunction

  function automatic void put_chunk(wavhp_pkg::tag_t t, logic [31:0] size, int body);
    put_tag(t);
    put_le(size, 4);
    put_rand(body);
  endfunction

  // fmt chunk with the fields first; short sizes cut the fields, long ones pad randomly
  function automatic void put_fmt_chunk(logic [31:0] size, wavhp_pkg::fmt_t f);
    logic [127:0] flat;
    logic [32:0] padded;
    flat = {f.bits_per_sample, f.frame_bytes, f.bytes_per_sec, f.sample_hz,
            f.channel_count, f.format_code};
    padded = ({1'b0, size} + 33'd1) & ~33'd1;
    put_tag(wavhp_pkg::TAG_FMT);
    put_le(size, 4);
    for (int k = 0; k < 16 && k < padded; k++) file_bytes.push_back(flat[8*k +: 8]);
    if (padded > 16) put_rand(int'(padded) - 16);
  endfunction

  function automatic wavhp_pkg::fmt_t random_fmt();
    wavhp_pkg::fmt_t f;
    case ($urandom_range(5))
      0: f.format_code = FMT_PCM;
      1: f.format_code = FMT_FLOAT;
      2: f.format_code = FMT_ALAW;
      3: f.format_code = FMT_MULAW;
      4: f.format_code = FMT_EXTENSIBLE;
      default: f.format_code = 16'($urandom);
    endcase
    f.channel_count = $urandom_range(1) ? 16'($urandom_range(1, 8)) : 16'($urandom);
    f.sample_hz = $urandom_range(1) ? 32'($urandom_range(8000, 192000)) : $urandom;
    f.bytes_per_sec = $urandom;
    f.frame_bytes = $urandom_range(1) ? 16'($urandom_range(1, 32)) : 16'($urandom);
    f.bits_per_sample = $urandom_range(1) ? 16'(8 * $urandom_range(1, 4)) : 16'($urandom);
    return f;
  endfunction

  // mostly the usual 16, sometimes extended, short or odd
  function automatic logic [31:0] fmt_size();
    case ($urandom_range(7))
      0: return 32'd18;
      1: return 32'd40;
      2: return 32'($urandom_range(0, 15));
      3: return 32'd17;
      default: return 32'd16;
    endcase
  endfunction

  // tags that must be skipped, including near misses of the two real ones
  function automatic wavhp_pkg::tag_t junk_tag();
    wavhp_pkg::tag_t t;
    int idx;
    idx = $urandom_range(3);
    case ($urandom_range(3))
      0: begin
        t = wavhp_pkg::TAG_FMT;
        t[idx] = t[idx] ^ 8'h20;
      end
      1: begin
        t = wavhp_pkg::TAG_DATA;
        t[idx] = t[idx] ^ 8'($urandom_range(1, 255));
      end
      2: t = TAG_LIST;
      default: t = $urandom;
    endcase
    return t;
  endfunction

  function automatic void put_junk();
    logic [31:0] size;
    if ($urandom_range(24) == 0) begin
      // skip longer than any buffer, the walk never gets out
      size = $urandom | 32'h8000_0000;
      put_chunk(junk_tag(), size, $urandom_range(0, 8));
    end else begin
      size = $urandom_range(0, 24);
      put_chunk(junk_tag(), size, (int'(size) + 1) & ~1);
    end
  endfunction

  function automatic void put_data();
    logic [31:0] size;
    int body;
    if ($urandom_range(9) < 7) begin
      size = $urandom_range(0, 40);
      body = (int'(size) + 1) & ~1;
    end else begin
      size = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - 32'($urandom_range(1));
      body = $urandom_range(0, 24);
    end
    put_chunk(wavhp_pkg::TAG_DATA, size, body);
  endfunction

  function automatic void build_well_formed();
    put_riff_head();
    if ($urandom_range(3) != 0) begin
      // usual layout: optional junk, fmt, optional junk, data, ignored tail
      if ($urandom_range(2) == 0) put_junk();
      put_fmt_chunk(fmt_size(), random_fmt());
      if ($urandom_range(2) == 0) put_junk();
      put_data();
      if ($urandom_range(3) == 0) put_junk();
    end else begin
      // chunks in any order, fmt and data may be missing or repeated
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(2))
          0: put_fmt_chunk(fmt_size(), random_fmt());
          1: put_junk();
          default: put_data();
        endcase
      end
    end
    put_rand($urandom_range(0, 8));
  endfunction

  // mostly well-formed buffers, the rest noise or broken headers
  function automatic void build_random_file();
    int pick;
    int idx;
    pick = $urandom_range(99);
    if (pick < 70) begin
      build_well_formed();
    end else if (pick < 82) begin
      put_rand($urandom_range(1, 90));
    end else begin
      build_well_formed();
      case ($urandom_range(2))
        0: begin
          idx = $urandom_range(0, 3);
          file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
        end
        1: begin
          idx = $urandom_range(8, 11);
          file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
        end
        default: begin
          repeat ($urandom_range(1, file_bytes.size() - 1)) void'(file_bytes.pop_back());
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // directed buffers for the corner cases of the walk
  // ---------------------------------------------------------------------------
  task automatic run_directed();
    wavhp_pkg::fmt_t pcm;
    wavhp_pkg::fmt_t alaw;
    wavhp_pkg::fmt_t ones;
    pcm = '{FMT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16};
    alaw = '{FMT_ALAW, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8};
    ones = '1;

    // a single byte, far below the minimum length
    file_bytes.push_back(8'hFF);
    send_file();

    // canonical 44-byte header, smallest buffer that can pass
    put_riff_head();
    put_fmt_chunk(32'd16, pcm);
    put_chunk(wavhp_pkg::TAG_DATA, 32'd0, 0);
    send_file();

    // same header one byte short
    put_riff_head();
    put_fmt_chunk(32'd16, pcm);
    put_chunk(wavhp_pkg::TAG_DATA, 32'd0, 0);
    void'(file_bytes.pop_back());
    send_file();

    // RIFF and WAVE both broken: the RIFF error takes priority
    put_riff_head();
    file_bytes[0] = 8'h72;
    file_bytes[9] = 8'h00;
    put_fmt_chunk(32'd16, pcm);
    put_chunk(wavhp_pkg::TAG_DATA, 32'd8, 8);
    send_file();

    // only the last WAVE byte wrong
    put_riff_head();
    file_bytes[11] = file_bytes[11] ^ 8'h01;
    put_fmt_chunk(32'd16, pcm);
    put_chunk(wavhp_pkg::TAG_DATA, 32'd8, 8);
    send_file();

    // fmt present, no data chunk; odd LIST size gets padded
    put_riff_head();
    put_fmt_chunk(32'd16, alaw);
    put_chunk(TAG_LIST, 32'd3, 4);
    put_rand(10);
    send_file();

    // data present, no fmt chunk
    put_riff_head();
    put_chunk(TAG_LIST, 32'd6, 6);
    put_chunk(wavhp_pkg::TAG_DATA, 32'd1001, 30);
    send_file();

    // two fmt chunks, the later one overwrites the first
    put_riff_head();
    put_fmt_chunk(32'd18, random_fmt());
    put_chunk(TAG_LIST, 32'd2, 2);
    put_fmt_chunk(32'd16, pcm);
    put_chunk(wavhp_pkg::TAG_DATA, 32'd4, 4);
    send_file();

    // empty fmt chunk: capture takes in the data header and the first eight payload bytes,
    // headers after the first data chunk are ignored
    put_riff_head();
    put_fmt_chunk(32'd0, pcm);
    put_chunk(wavhp_pkg::TAG_DATA, 32'd12, 12);
    put_fmt_chunk(32'd16, ones);
    put_chunk(wavhp_pkg::TAG_DATA, 32'd2, 2);
    send_file();

    // buffer ends five bytes into the fmt capture
    put_riff_head();
    put_chunk(TAG_LIST, 32'd24, 24);
    put_tag(wavhp_pkg::TAG_FMT);
    put_le(32'd16, 4);
    put_rand(5);
    send_file();

    // all-ones fmt, data size of all ones pads to 2^32 and wraps to zero
    put_riff_head();
    put_fmt_chunk(32'd16, ones);
    put_chunk(TAG_LIST, 32'd3, 4);
    put_chunk(wavhp_pkg::TAG_DATA, 32'hFFFF_FFFF, 6);
    send_file();

    // all-zero fmt, largest even data size kept as is
    put_riff_head();
    put_fmt_chunk(32'd16, '0);
    put_chunk(wavhp_pkg::TAG_DATA, 32'hFFFF_FFFE, 2);
    send_file();

    // huge junk size: the data header behind it is never reached
    put_riff_head();
    put_fmt_chunk(32'd16, pcm);
    put_chunk(TAG_LIST, 32'hFFFF_FFFF, 8);
    put_chunk(wavhp_pkg::TAG_DATA, 32'd4, 4);
    send_file();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase_end;
    tracker = new();
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    bytes_sent = 0;
    random_files = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // random phases: no idling, sender idle, receiver stalls, both a little
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct = 10;
          recv_stall_pct = 10;
        end
      endcase
      phase_end = bytes_sent + RANDOM_BYTES_PER_PHASE;
      while (bytes_sent < phase_end || (ph == 3 && random_files < MIN_RANDOM_FILES)) begin
        build_random_file();
        send_file();
        random_files++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
